### rtl/dptu_pkg.sv
package dptu_pkg;

  localparam int DIV_PERIOD_DEF      = 64;
  localparam int MAX_TICK_CYCLES_DEF = 63;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  localparam int          DIV_EDGE_BIT = 4;
  localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;
  localparam logic [2:0]  OVF_DELAY     = 3'd4;
  localparam int          CTRL_ENABLE   = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  cycles;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       audio_div_pulse;
    logic       irq_request;
  } out_t;

  // counter prescaler period by control[1:0]
  function automatic logic [8:0] prescale(input logic [1:0] sel);
    logic [8:0] p;
    case (sel)
      2'd0:    p = 9'd256;
      2'd1:    p = 9'd4;
      2'd2:    p = 9'd16;
      2'd3:    p = 9'd64;
      default: p = 9'd256;
    endcase
    return p;
  endfunction

endpackage

### rtl/divider_and_prescaled_timer_unit.sv
// Divider and prescaled timer. Each input transfer is a tick (cycle count),
// a bus write or a bus read of the divider (FF04), counter (FF05), modulo
// (FF06) or control (FF07) register; each produces exactly one result
// transfer. Reads and writes go through S_DONE to the result register. A
// tick runs a small sequencer around one shared subtract/compare unit:
// S_DIV takes DIV_PERIOD from the divider total while it can, then, with
// the timer enabled, S_DLY works off the pending overflow delay and S_CNT
// takes one counter step per prescaler period, then S_DONE hands off the
// result. The input is stalled while an item is in progress; a finished
// result may wait in the output register while the next item runs.
module divider_and_prescaled_timer_unit import dptu_pkg::*; #(
  parameter int DIV_PERIOD      = DIV_PERIOD_DEF,
  parameter int MAX_TICK_CYCLES = MAX_TICK_CYCLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // work width: holds MAX_TICK_CYCLES + 255 and DIV_PERIOD
  localparam int AW  = $clog2(MAX_TICK_CYCLES + 256);
  localparam int DRW = (DIV_PERIOD > 1) ? $clog2(DIV_PERIOD) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,   // reduce divider total by DIV_PERIOD
    S_DLY,   // pending overflow delay
    S_CNT,   // counter steps, one per prescaler period
    S_DONE   // hand result to output register
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      div_r, div_nxt;
  logic [DRW-1:0]  dr_r, dr_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [7:0]      cr_r, cr_nxt;
  logic [7:0]      mod_r, mod_nxt;
  logic [3:0]      ctrl_r, ctrl_nxt;
  logic [2:0]      dly_r, dly_nxt;
  logic [AW-1:0]   w_r, w_nxt;        // running total under reduction
  logic [AW-1:0]   cyc_r, cyc_nxt;    // saturated tick cycles
  logic            stepped_r, stepped_nxt;
  out_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic [AW-1:0]   cyc_sat;
  logic [AW-1:0]   op_a, op_b, diff;
  logic            ge;
  logic [7:0]      div_inc;

  dptu_sub #(.W(AW)) u_sub (
    .a    (op_a),
    .b    (op_b),
    .ge   (ge),
    .diff (diff)
  );

  assign cyc_sat = (AW'(in_data.cycles) > AW'(MAX_TICK_CYCLES)) ?
                   AW'(MAX_TICK_CYCLES) : AW'(in_data.cycles);
  assign div_inc = div_r + 8'd1;

  // operand select for the shared unit
  always_comb begin
    op_a = w_r;
    op_b = AW'(DIV_PERIOD);
    case (state_r)
      S_DIV: begin
        op_a = w_r;
        op_b = AW'(DIV_PERIOD);
      end
      S_DLY: begin
        op_a = AW'(dly_r);
        op_b = w_r;
      end
      S_CNT: begin
        op_a = w_r;
        op_b = AW'(prescale(ctrl_r[1:0]));
      end
      default: begin
        op_a = w_r;
        op_b = AW'(DIV_PERIOD);
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    div_nxt       = div_r;
    dr_nxt        = dr_r;
    cnt_nxt       = cnt_r;
    cr_nxt        = cr_r;
    mod_nxt       = mod_r;
    ctrl_nxt      = ctrl_r;
    dly_nxt       = dly_r;
    w_nxt         = w_r;
    cyc_nxt       = cyc_r;
    stepped_nxt   = stepped_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // output register drains on transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_data.opcode)
            OP_TICK: begin
              cyc_nxt     = cyc_sat;
              w_nxt       = cyc_sat + AW'(dr_r);
              stepped_nxt = 1'b0;
              state_nxt   = S_DIV;
            end
            OP_WRITE: begin
              case (in_data.bus_address)
                ADDR_DIVIDER: begin
                  res_nxt.audio_div_pulse = div_r[DIV_EDGE_BIT];
                  div_nxt = '0;
                  dr_nxt  = '0;
                end
                ADDR_COUNTER: begin
                  cnt_nxt = in_data.write_data;
                  cr_nxt  = '0;
                end
                ADDR_MODULO:  mod_nxt  = in_data.write_data;
                ADDR_CONTROL: ctrl_nxt = in_data.write_data[3:0];
                default: ;
              endcase
            end
            OP_READ: begin
              case (in_data.bus_address)
                ADDR_DIVIDER: res_nxt.read_data = div_r;
                ADDR_COUNTER: res_nxt.read_data = cnt_r;
                ADDR_MODULO:  res_nxt.read_data = mod_r;
                ADDR_CONTROL: res_nxt.read_data = {4'd0, ctrl_r};
                default:      res_nxt.read_data = BYTE_ALL_ONES;
              endcase
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        if (ge) begin
          w_nxt = diff;
          // divider steps at most once per tick
          if (!stepped_r) begin
            stepped_nxt = 1'b1;
            div_nxt     = div_inc;
            if (div_r[DIV_EDGE_BIT] && !div_inc[DIV_EDGE_BIT]) begin
              res_nxt.audio_div_pulse = 1'b1;
            end
          end
        end else begin
          dr_nxt = w_r[DRW-1:0];
          if (ctrl_r[CTRL_ENABLE]) begin
            w_nxt     = cyc_r + AW'(cr_r);
            state_nxt = S_DLY;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DLY: begin
        if (dly_r != 3'd0) begin
          if (ge && (diff != '0)) begin
            dly_nxt = diff[2:0];
          end else begin
            cnt_nxt             = mod_r;
            res_nxt.irq_request = 1'b1;
            dly_nxt             = 3'd0;
          end
        end
        state_nxt = S_CNT;
      end

      S_CNT: begin
        if (ge) begin
          w_nxt = diff;
          if (cnt_r == BYTE_ALL_ONES) begin
            cnt_nxt = mod_r;
            dly_nxt = OVF_DELAY;
          end else begin
            cnt_nxt = cnt_r + 8'd1;
          end
        end else begin
          cr_nxt    = w_r[7:0];
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_r       <= '0;
      dr_r        <= '0;
      cnt_r       <= '0;
      cr_r        <= '0;
      mod_r       <= '0;
      ctrl_r      <= '0;
      dly_r       <= '0;
      stepped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_r       <= div_nxt;
      dr_r        <= dr_nxt;
      cnt_r       <= cnt_nxt;
      cr_r        <= cr_nxt;
      mod_r       <= mod_nxt;
      ctrl_r      <= ctrl_nxt;
      dly_r       <= dly_nxt;
      stepped_r   <= stepped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    cyc_r      <= cyc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/dptu_sub.sv
// shared compare/subtract unit
module dptu_sub import dptu_pkg::*; #(
  parameter int W = 9
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign ge   = ~full[W];
  assign diff = full[W-1:0];

endmodule

### verif/dptu_timer_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the timer unit and keeps its own copy of the
// timer state. It predicts one result per input transfer and checks
// output transfers in order.
module dptu_timer_checker import dptu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   pulse_count,
  output int   irq_count
);

  logic [7:0] div_q;
  logic [5:0] div_frac;
  logic [7:0] tima;
  logic [7:0] tima_frac;
  logic [7:0] tma;
  logic [3:0] tac;
  logic [2:0] ovf_wait;

  out_t expected_q[$];
  int   fails  = 0;
  int   pulses = 0;
  int   irqs   = 0;

  function automatic int timer_period(input logic [1:0] sel);
    int p;
    case (sel)
      2'd0:    p = 256;
      2'd1:    p = 4;
      2'd2:    p = 16;
      default: p = 64;
    endcase
    return p;
  endfunction

  // one transfer through the timer state, returns the expected result
  task automatic timer_step(input in_t it, output out_t res);
    int total;
    int period;
    int steps;
    logic [7:0] prev_div;
    res = '0;
    case (it.opcode)
      OP_TICK: begin
        total = int'(it.cycles) + int'(div_frac);
        if (total >= DIV_PERIOD_DEF) begin
          prev_div = div_q;
          div_q = div_q + 8'd1;
          if (prev_div[DIV_EDGE_BIT] && !div_q[DIV_EDGE_BIT])
            res.audio_div_pulse = 1'b1;
        end
        div_frac = 6'(total % DIV_PERIOD_DEF);
        if (tac[CTRL_ENABLE]) begin
          total = int'(it.cycles) + int'(tima_frac);
          if (ovf_wait != 3'd0) begin
            if (int'(ovf_wait) > total) begin
              ovf_wait = 3'(int'(ovf_wait) - total);
            end else begin
              tima = tma;
              res.irq_request = 1'b1;
              ovf_wait = 3'd0;
            end
          end
          period = timer_period(tac[1:0]);
          steps = total / period;
          tima_frac = 8'(total % period);
          repeat (steps) begin
            if (tima == BYTE_ALL_ONES) begin
              tima = tma;
              ovf_wait = OVF_DELAY;
            end else begin
              tima = tima + 8'd1;
            end
          end
        end
      end
      OP_WRITE: begin
        case (it.bus_address)
          ADDR_DIVIDER: begin
            res.audio_div_pulse = div_q[DIV_EDGE_BIT];
            div_q = '0;
            div_frac = '0;
          end
          ADDR_COUNTER: begin
            tima = it.write_data;
            tima_frac = '0;
          end
          ADDR_MODULO:  tma = it.write_data;
          ADDR_CONTROL: tac = it.write_data[3:0];
          default: ;
        endcase
      end
      OP_READ: begin
        case (it.bus_address)
          ADDR_DIVIDER: res.read_data = div_q;
          ADDR_COUNTER: res.read_data = tima;
          ADDR_MODULO:  res.read_data = tma;
          ADDR_CONTROL: res.read_data = {4'd0, tac};
          default:      res.read_data = BYTE_ALL_ONES;
        endcase
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    logic bad;
    if (!rst_n) begin
      div_q     = '0;
      div_frac  = '0;
      tima      = '0;
      tima_frac = '0;
      tma       = '0;
      tac       = '0;
      ovf_wait  = '0;
      expected_q.delete();
    end else begin
      // retire first: a result never belongs to an item taken at this edge
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result %p with nothing outstanding", $time, out_data);
        end else begin
          want = expected_q.pop_front();
          bad = 1'b0;
          if (out_data.read_data !== want.read_data) begin
            bad = 1'b1;
            $display("%0t: read_data expected %h got %h", $time,
                     want.read_data, out_data.read_data);
          end
          if (out_data.audio_div_pulse !== want.audio_div_pulse) begin
            bad = 1'b1;
            $display("%0t: audio_div_pulse expected %b got %b", $time,
                     want.audio_div_pulse, out_data.audio_div_pulse);
          end
          if (out_data.irq_request !== want.irq_request) begin
            bad = 1'b1;
            $display("%0t: irq_request expected %b got %b", $time,
                     want.irq_request, out_data.irq_request);
          end
          if (bad)
            fails++;
          if (want.audio_div_pulse)
            pulses++;
          if (want.irq_request)
            irqs++;
        end
      end
      if (in_valid && !in_stall) begin
        timer_step(in_data, want);
        expected_q.push_back(want);
      end
    end
    fail_count  <= fails;
    pending     <= expected_q.size();
    pulse_count <= pulses;
    irq_count   <= irqs;
  end

endmodule

### verif/divider_and_prescaled_timer_unit_test.sv
`timescale 1ns / 100ps

// Top of the timer unit bench: clock, reset, stimulus and the verdict.
// All checking lives in dptu_timer_checker, which sits beside the dut.
module divider_and_prescaled_timer_unit_test;
  import dptu_pkg::*;

  // opcode the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 630;
  localparam int LONG_HOLD    = 400;   // receiver hold-off, cycles
  localparam int TAIL_CYCLES  = 200;   // idle tail after the final drain
  localparam int TIMEOUT_NS   = 5000000;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  // set by the stimulus; the receiver answers it once
  logic hold_off_req = 1'b0;

  int fail_count;
  int pending;
  int pulse_count;
  int irq_count;

  int items_sent = 0;
  int burst_left = 0;
  int read_count = 0;

  divider_and_prescaled_timer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  dptu_timer_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .pulse_count (pulse_count),
    .irq_count   (irq_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake locks up
  initial begin
    #(TIMEOUT_NS);
    $display("[divider_and_prescaled_timer_unit] ERROR");
    $finish;
  end

  function automatic in_t make_item(input logic [1:0] op, input logic [5:0] cyc,
                                    input logic [15:0] addr, input logic [7:0] data);
    in_t it;
    it.opcode      = op;
    it.cycles      = cyc;
    it.bus_address = addr;
    it.write_data  = data;
    return it;
  endfunction

  function automatic logic [15:0] timer_addr();
    logic [15:0] a;
    case ($urandom_range(3))
      0:       a = ADDR_DIVIDER;
      1:       a = ADDR_COUNTER;
      2:       a = ADDR_MODULO;
      default: a = ADDR_CONTROL;
    endcase
    return a;
  endfunction

  // Mostly ticks against a running timer. Writes lean toward values that
  // keep the counter enabled and close to overflow, so reloads and
  // interrupts come often; a few transfers hit stray addresses or the
  // unused opcode.
  function automatic in_t random_item();
    in_t it;
    int  pick;
    int  roll;
    it.cycles      = 6'($urandom_range(63));
    it.bus_address = 16'($urandom_range(16'hFFFF));
    it.write_data  = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 58) begin
      it.opcode = OP_TICK;
      roll = $urandom_range(99);
      if (roll < 20)
        it.cycles = 6'd63;
      else if (roll < 25)
        it.cycles = 6'd0;
    end else if (pick < 74) begin
      it.opcode = OP_WRITE;
      if ($urandom_range(9) != 0)
        it.bus_address = timer_addr();
      case (it.bus_address)
        ADDR_CONTROL: begin
          if ($urandom_range(3) != 0)
            it.write_data[CTRL_ENABLE] = 1'b1;
        end
        ADDR_COUNTER, ADDR_MODULO: begin
          if ($urandom_range(1) != 0)
            it.write_data = 8'($urandom_range(255, 8'hF0));
        end
        default: ;
      endcase
    end else if (pick < 95) begin
      it.opcode = OP_READ;
      if ($urandom_range(6) != 0)
        it.bus_address = timer_addr();
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one transfer and hold it until taken, then maybe go quiet for a
  // while. Bursts of random length alternate with random gaps; about a
  // third of the bursts run back to back with no gap at all.
  task automatic send(input in_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (it.opcode == OP_READ)
      read_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(15, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: switches between stall patterns of random length. When asked,
  // it holds off for the LONG_HOLD period so the dut backs up onto its input.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    int       k;
    logic     held;
    mode      = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    held      = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held      = 1'b1;
        out_stall <= 1'b1;
        for (k = 0; k < LONG_HOLD; k++)
          @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(3));
          mode_left = $urandom_range(200, 10);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(99) < 30);
          RX_HEAVY: out_stall <= ($urandom_range(99) < 75);
          default:  out_stall <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, stray addresses and the unused opcode
    send(make_item(OP_READ, 6'd0, ADDR_DIVIDER, 8'h00));
    send(make_item(OP_READ, 6'd63, ADDR_COUNTER, 8'hFF));
    send(make_item(OP_READ, 6'd0, ADDR_MODULO, 8'h00));
    send(make_item(OP_READ, 6'd0, ADDR_CONTROL, 8'h00));
    send(make_item(OP_READ, 6'd0, 16'h0000, 8'h00));
    send(make_item(OP_READ, 6'd0, 16'hFFFF, 8'hFF));
    send(make_item(OP_UNUSED, 6'd63, 16'hFFFF, 8'hFF));
    // timer off: only the divider moves; second tick crosses one period
    send(make_item(OP_TICK, 6'd63, 16'h0000, 8'h00));
    send(make_item(OP_TICK, 6'd1, 16'h0000, 8'h00));
    // enable at prescaler 4, upper control bits dropped; counter at the top
    send(make_item(OP_WRITE, 6'd0, ADDR_CONTROL, 8'hFD));
    send(make_item(OP_WRITE, 6'd0, ADDR_MODULO, 8'hFE));
    send(make_item(OP_WRITE, 6'd0, ADDR_COUNTER, 8'hFF));
    // overflow, then a zero-cycle tick that leaves the delay pending,
    // then the tick that raises the interrupt
    send(make_item(OP_TICK, 6'd63, 16'h0000, 8'h00));
    send(make_item(OP_TICK, 6'd0, 16'h0000, 8'h00));
    send(make_item(OP_TICK, 6'd63, 16'h0000, 8'h00));
    // write to a neighbor of the timer block is dropped
    send(make_item(OP_WRITE, 6'd0, 16'hFF03, 8'h55));
    send(make_item(OP_READ, 6'd0, ADDR_CONTROL, 8'h00));
    send(make_item(OP_READ, 6'd0, ADDR_COUNTER, 8'h00));
    send(make_item(OP_READ, 6'd0, ADDR_MODULO, 8'h00));
    // divider write clears it whatever the data
    send(make_item(OP_WRITE, 6'd0, ADDR_DIVIDER, 8'hFF));
    send(make_item(OP_READ, 6'd0, ADDR_DIVIDER, 8'h00));
    // disabled timer holds; then the slow 256 prescaler
    send(make_item(OP_WRITE, 6'd0, ADDR_CONTROL, 8'h00));
    send(make_item(OP_TICK, 6'd63, 16'h0000, 8'h00));
    send(make_item(OP_WRITE, 6'd0, ADDR_CONTROL, 8'h04));
    send(make_item(OP_TICK, 6'd63, 16'h0000, 8'h00));
    drain();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold-off while the sender keeps offering
      if (i == 150)
        hold_off_req <= 1'b1;
      // sender pauses until the pipe is empty
      if (i == 300 || i == 480)
        drain();
      send(random_item());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transfers (%0d reads): every register read and written,",
             items_sent, read_count);
    $display("stray addresses, unused opcode, all prescalers; %0d divider pulses, %0d irqs.",
             pulse_count, irq_count);
    if (fail_count == 0) begin
      $display("[divider_and_prescaled_timer_unit] OK");
    end else begin
      $display("[divider_and_prescaled_timer_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/dptu_pkg.sv
rtl/dptu_sub.sv
rtl/divider_and_prescaled_timer_unit.sv
verif/dptu_timer_checker.sv
verif/divider_and_prescaled_timer_unit_test.sv
